// ----- rtl/cotp_pkg.sv -----
// Shared types and constants for the chunk offset table patcher.
`timescale 1ns / 1ps

package cotp_pkg;

    // Atom type tags, as they read in big-endian byte order.
    localparam logic [31:0] TAG_STCO = 32'h7374_636F;
    localparam logic [31:0] TAG_CO64 = 32'h636F_3634;
    localparam logic [31:0] TAG_CMOV = 32'h636D_6F76;

    // Position of the last byte of a compressed-moov type tag.
    localparam logic [31:0] CMOV_END_POS = 32'd15;

    // Smallest atom size that holds a full table header.
    localparam logic [31:0] MIN_ATOM_SIZE = 32'd16;

    // Reset value of the moov length register.
    localparam logic [31:0] MOOV_LENGTH_RESET = 32'd16;

    // Output byte queue depth and its occupancy width.
    localparam int QDEPTH = 16;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Largest number of results one input transaction can give.
    localparam int MAX_GROUP = 8;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CMOV      = 2'd1,
        ST_BAD_SIZE  = 2'd2,
        ST_BAD_COUNT = 2'd3
    } status_t;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_SCAN    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_COUNT   = 3'd2,
        PH_ENTRIES = 3'd3,
        PH_ERROR   = 3'd4
    } phase_t;

    // Results of one input transaction: the low count bytes of data go out
    // most significant first, last marks the final one.
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
        status_t     status;
    } cotp_group_t;

    // One queued result transaction.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        status_t    status;
    } cotp_entry_t;

endpackage

// ----- rtl/cotp_regs.sv -----
// APB configuration register holding the moov length.
`timescale 1ns / 1ps

module cotp_regs
    import cotp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] moov_length
);

    logic [31:0] moov_length_reg;
    logic [31:0] moov_length_next;
    logic        sel_moov;

    // Only the word at byte address zero is a register.
    assign sel_moov = (paddr[2] == 1'b0);
    assign pready   = 1'b1;

    // Write on the access cycle of a write transaction.
    always_comb begin
        moov_length_next = moov_length_reg;
        if (psel && penable && pwrite && pready && sel_moov) begin
            moov_length_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            moov_length_reg <= MOOV_LENGTH_RESET;
        end else begin
            moov_length_reg <= moov_length_next;
        end
    end

    assign prdata      = sel_moov ? moov_length_reg : 32'd0;
    assign moov_length = moov_length_reg;

endmodule

// ----- rtl/cotp_parser.sv -----
// Byte parser: tag scan, table header decode and chunk offset patching.
`timescale 1ns / 1ps

module cotp_parser
    import cotp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    input  logic [31:0] moov_length,
    output cotp_group_t group
);

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [63:0] recent_reg, recent_next;
    logic [31:0] entries_reg, entries_next;
    logic [63:0] acc_reg, acc_next;
    logic [2:0]  idx_reg, idx_next;
    logic        wide_reg, wide_next;
    logic [31:0] resume_reg, resume_next;

    logic [63:0] rb;
    logic [31:0] tag;
    logic [3:0]  idx_inc;
    logic [31:0] tag_pos;
    logic        tag_seen;
    logic        in_window;
    logic        tag_hit;
    logic [33:0] size_sum;
    logic        bad_size;
    logic [33:0] resume_sum;
    logic        cmov_hit;
    logic        hdr_done;
    logic [31:0] ent_new;
    logic [35:0] span;
    logic [35:0] table_end;
    logic        cnt_done;
    logic        cnt_bad;
    logic [3:0]  ent_width;
    logic        ent_done;
    logic [63:0] acc_new;
    logic [63:0] patched_sum;
    logic [63:0] patched;

    // Byte history with the new byte shifted in.
    assign rb      = {recent_reg[55:0], data_byte};
    assign tag     = rb[31:0];
    assign idx_inc = {1'b0, idx_reg} + 4'd1;

    // A stco or co64 tag seen at its start position, inside the moov.
    assign tag_pos   = pos_reg - 32'd3;
    assign tag_seen  = (pos_reg >= 32'd7) && ((tag == TAG_STCO) || (tag == TAG_CO64));
    assign in_window = (({1'b0, tag_pos} + 33'd4) < {1'b0, moov_length})
                       && (tag_pos >= resume_reg);
    assign tag_hit   = (phase_reg == PH_SCAN) && tag_seen && in_window;

    // Atom size checks, and the resume point two bytes past the atom's last byte.
    assign size_sum   = {2'b00, tag_pos} + {2'b00, rb[63:32]};
    assign bad_size   = (rb[63:32] < MIN_ATOM_SIZE)
                        || ((size_sum - 34'd4) > {2'b00, moov_length});
    assign resume_sum = size_sum - 34'd3;

    // Compressed moov tag at bytes 12 to 15.
    assign cmov_hit = (pos_reg == CMOV_END_POS) && (phase_reg != PH_ENTRIES)
                      && (phase_reg != PH_ERROR) && (tag == TAG_CMOV);

    // Header skip and entry count decode.
    assign hdr_done  = (idx_inc == 4'd4);
    assign ent_new   = {entries_reg[23:0], data_byte};
    assign span      = wide_reg ? {1'b0, ent_new, 3'b000} : {2'b00, ent_new, 2'b00};
    assign table_end = {4'b0000, pos_reg} + 36'd1 + span;
    assign cnt_done  = (idx_inc == 4'd4);
    assign cnt_bad   = (table_end > {4'b0000, moov_length});

    // Entry collection and the offset adjustment.
    assign ent_width   = wide_reg ? 4'd8 : 4'd4;
    assign ent_done    = (idx_inc == ent_width);
    assign acc_new     = {acc_reg[55:0], data_byte};
    assign patched_sum = acc_new + {32'd0, moov_length};
    assign patched     = wide_reg ? patched_sum : {32'd0, patched_sum[31:0]};

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            if (phase_reg != PH_ERROR) begin
                if (cmov_hit) begin
                    phase_next = PH_ERROR;
                end else begin
                    case (phase_reg)
                        PH_SCAN: begin
                            if (tag_hit) begin
                                phase_next = bad_size ? PH_ERROR : PH_HEADER;
                            end
                        end
                        PH_HEADER: begin
                            if (hdr_done) begin
                                phase_next = PH_COUNT;
                            end
                        end
                        PH_COUNT: begin
                            if (cnt_done) begin
                                if (cnt_bad) begin
                                    phase_next = PH_ERROR;
                                end else if (ent_new == 32'd0) begin
                                    phase_next = PH_SCAN;
                                end else begin
                                    phase_next = PH_ENTRIES;
                                end
                            end
                        end
                        PH_ENTRIES: begin
                            if (ent_done && (entries_reg == 32'd1)) begin
                                phase_next = PH_SCAN;
                            end
                        end
                        default: begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
            if (is_last) begin
                phase_next = PH_SCAN;
            end
        end
    end

    // Datapath state and the results of this transaction.
    always_comb begin
        pos_next     = pos_reg;
        recent_next  = recent_reg;
        entries_next = entries_reg;
        acc_next     = acc_reg;
        idx_next     = idx_reg;
        wide_next    = wide_reg;
        resume_next  = resume_reg;
        group        = '0;
        if (accept) begin
            pos_next = pos_reg + 32'd1;
            if (phase_reg != PH_ERROR) begin
                recent_next  = rb;
                group.data   = {56'd0, data_byte};
                group.count  = 4'd1;
                group.last   = is_last;
                group.status = ST_OK;
                if (cmov_hit) begin
                    group.data   = '0;
                    group.last   = 1'b1;
                    group.status = ST_CMOV;
                end else begin
                    case (phase_reg)
                        PH_SCAN: begin
                            if (tag_hit) begin
                                if (bad_size) begin
                                    group.data   = '0;
                                    group.last   = 1'b1;
                                    group.status = ST_BAD_SIZE;
                                end else begin
                                    wide_next    = (tag == TAG_CO64);
                                    resume_next  = (resume_sum[33:32] != 2'b00) ?
                                                   32'hFFFF_FFFF : resume_sum[31:0];
                                    entries_next = 32'd0;
                                    idx_next     = 3'd0;
                                end
                            end
                        end
                        PH_HEADER: begin
                            idx_next = hdr_done ? 3'd0 : idx_inc[2:0];
                        end
                        PH_COUNT: begin
                            entries_next = ent_new;
                            idx_next     = idx_inc[2:0];
                            if (cnt_done) begin
                                idx_next = 3'd0;
                                acc_next = '0;
                                if (cnt_bad) begin
                                    group.data   = '0;
                                    group.last   = 1'b1;
                                    group.status = ST_BAD_COUNT;
                                end
                            end
                        end
                        PH_ENTRIES: begin
                            acc_next    = acc_new;
                            idx_next    = idx_inc[2:0];
                            group.count = 4'd0;
                            if (ent_done) begin
                                // Write the patched entry back into the history.
                                recent_next  = wide_reg ? patched : {rb[63:32], patched[31:0]};
                                group.data   = patched;
                                group.count  = ent_width;
                                group.last   = is_last;
                                idx_next     = 3'd0;
                                acc_next     = '0;
                                entries_next = entries_reg - 32'd1;
                            end else if (is_last) begin
                                // Atom ended inside an entry: flush the held bytes as read.
                                group.data  = acc_new;
                                group.count = idx_inc;
                                group.last  = 1'b1;
                            end
                        end
                        default: begin
                            group.count = 4'd0;
                        end
                    endcase
                end
            end
            // The final byte returns the parser to its reset state.
            if (is_last) begin
                pos_next     = '0;
                recent_next  = '0;
                entries_next = '0;
                acc_next     = '0;
                idx_next     = '0;
                wide_next    = 1'b0;
                resume_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SCAN;
            pos_reg     <= '0;
            recent_reg  <= '0;
            entries_reg <= '0;
            acc_reg     <= '0;
            idx_reg     <= '0;
            wide_reg    <= 1'b0;
            resume_reg  <= '0;
        end else begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            recent_reg  <= recent_next;
            entries_reg <= entries_next;
            acc_reg     <= acc_next;
            idx_reg     <= idx_next;
            wide_reg    <= wide_next;
            resume_reg  <= resume_next;
        end
    end

endmodule

// ----- rtl/cotp_outq.sv -----
// Output byte queue: takes up to eight results at once, sends one per cycle while popped.
`timescale 1ns / 1ps

module cotp_outq
    import cotp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cotp_group_t       group,
    input  logic              pop,
    output cotp_entry_t       head,
    output logic [QCNT_W-1:0] count
);

    cotp_entry_t       q_reg [QDEPTH];
    cotp_entry_t       q_next [QDEPTH];
    cotp_entry_t       shifted [QDEPTH];
    cotp_entry_t       emit [MAX_GROUP];
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QCNT_W-1:0] base;
    logic [QCNT_W-1:0] rel [QDEPTH];
    logic [63:0]       aligned;
    logic [6:0]        align_shift;

    // Put the first byte to send into the top byte lane.
    assign align_shift = {4'd8 - group.count, 3'b000};
    assign aligned     = group.data << align_shift;

    // Results of the incoming group in sending order.
    always_comb begin
        for (int j = 0; j < MAX_GROUP; j++) begin
            emit[j].out_byte = aligned[63 - 8 * j -: 8];
            emit[j].out_last = group.last && (4'(j + 1) == group.count);
            emit[j].status   = group.status;
        end
    end

    // Queue contents after the head leaves.
    always_comb begin
        for (int i = 0; i < QDEPTH - 1; i++) begin
            shifted[i] = pop ? q_reg[i + 1] : q_reg[i];
        end
        shifted[QDEPTH - 1] = q_reg[QDEPTH - 1];
    end

    // New results land right behind what stays in the queue.
    assign base = count_reg - {{(QCNT_W - 1){1'b0}}, pop};

    always_comb begin
        for (int i = 0; i < QDEPTH; i++) begin
            rel[i]    = QCNT_W'(i) - base;
            q_next[i] = shifted[i];
            if ((QCNT_W'(i) >= base) && (rel[i] < {{(QCNT_W - 4){1'b0}}, group.count})) begin
                q_next[i] = emit[rel[i][2:0]];
            end
        end
    end

    assign count_next = base + {{(QCNT_W - 4){1'b0}}, group.count};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    assign head  = q_reg[0];
    assign count = count_reg;

endmodule

// ----- rtl/chunk_offset_table_patcher.sv -----
// Top level of the chunk offset table patcher.
`timescale 1ns / 1ps

// Streams the bytes of a moov atom through and patches stco and co64 tables.
// Input channel s_*: one byte per transaction, s_tlast on the final byte.
// Result channel m_*: one byte per transaction with m_tlast and a status code
// in m_tuser; a fault gives one zero byte with m_tlast set and nonzero status,
// after which the rest of the atom gives no results.
// moov_length is written over the APB port at address 0; the user must write
// it only while idle, which the block does not enforce. Each byte is decoded
// in the cycle it is accepted; its results are written into a 16-entry output
// queue, where they stand from the cycle after acceptance. Table entry bytes
// are held until the entry is complete and then enter the queue together as
// 4 or 8 results. Throughput is one byte per cycle in both directions while
// the receiver is ready; s_tready is high while the queue holds 8 or fewer
// results, so a full entry always fits. When the receiver stalls, the queue
// fills and then s_tready drops. Reset (synchronous, active low) empties the
// queue, clears the parser and sets moov_length back to 16.
module chunk_offset_table_patcher
    import cotp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input byte stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // [1:0] status
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0]       moov_length;
    logic              in_accept;
    logic              pop;
    cotp_group_t       group;
    cotp_entry_t       head;
    logic [QCNT_W-1:0] q_count;

    cotp_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .moov_length (moov_length)
    );

    // Room for a full co64 entry is kept free before taking a byte.
    assign s_tready  = (q_count <= QCNT_W'(QDEPTH - MAX_GROUP));
    assign in_accept = s_tvalid && s_tready;

    cotp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (in_accept),
        .data_byte   (s_tdata),
        .is_last     (s_tlast),
        .moov_length (moov_length),
        .group       (group)
    );

    assign pop = m_tvalid && m_tready;

    cotp_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .group   (group),
        .pop     (pop),
        .head    (head),
        .count   (q_count)
    );

    assign m_tvalid = (q_count != '0);
    assign m_tdata  = head.out_byte;
    assign m_tlast  = head.out_last;
    assign m_tuser  = head.status;

    // The queue never holds more than its depth.
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= QCNT_W'(QDEPTH))
        else $error("output queue overflow");

    // A fault result always closes the atom and carries a zero byte.
    a_fault_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tlast && (m_tdata == 8'd0)))
        else $error("fault result without last flag or with data");

    // After reset nothing is offered on the result side.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Results only appear after an input byte was taken.
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(q_count) == '0 && !$past(in_accept)) |-> !m_tvalid)
        else $error("result appeared without an input transaction");

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the chunk offset table patcher.
`timescale 1ns / 1ps

module testbench;
    import cotp_pkg::*;

    // Run control.
    localparam int          CYCLE_LIMIT        = 200000;
    localparam int          DRAIN_CYCLES       = 24;
    localparam int          HOLD_CYCLES        = 90;
    localparam int          RANDOM_ITEM_TARGET = 130;
    localparam logic [2:0]  MOOV_LENGTH_ADDR   = 3'd0;
    localparam logic [31:0] MOOV_TAG           = 32'h6D6F_6F76;
    localparam logic [31:0] FREE_TAG           = 32'h6672_6565;

    // Kinds of generated moov atoms.
    typedef enum int {
        SH_STCO,
        SH_CO64,
        SH_BAD_SIZE,
        SH_BAD_COUNT,
        SH_CUT,
        SH_CMOV,
        SH_NOISE
    } atom_shape_e;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } stream_byte_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
        status_t    status;
    } patched_byte_t;

    // Clock, reset and the block's inputs, all known from time zero.
    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Stimulus and scoreboard storage.
    stream_byte_t  pending_bytes[$];
    patched_byte_t expected_bytes[$];
    logic [7:0]    image_bytes[$];
    stream_byte_t  next_item;
    patched_byte_t oldest;
    int            atom_cut;
    int            entries_at;
    logic [31:0]   atom_moov_len;
    int            random_items   = 0;
    int            mismatch_count = 0;
    int            results_seen   = 0;
    int            cycle_count    = 0;
    bit            in_taken       = 1'b0;
    bit            hold_req       = 1'b0;

    // Driver and receiver pacing.
    int          burst_left = 1;
    int          gap_left   = 0;
    int          hold_left  = 0;
    bit          hold_done  = 1'b0;
    logic [15:0] stall_mask = 16'hFFFF;
    int          stall_slot = 0;

    // Predictor state.
    logic [31:0] moov_len_model;
    logic [31:0] next_pos;
    logic [63:0] byte_window;
    phase_t      table_phase;
    logic [31:0] entries_remaining;
    logic [63:0] entry_bytes;
    int          entry_fill;
    bit          table_wide;
    logic [31:0] rescan_from;

    chunk_offset_table_patcher dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Per-atom parser state returns to idle after every final byte.
    task automatic clear_scan_state();
        next_pos          = 32'd0;
        byte_window       = 64'd0;
        table_phase       = PH_SCAN;
        entries_remaining = 32'd0;
        entry_bytes       = 64'd0;
        entry_fill        = 0;
        table_wide        = 1'b0;
        rescan_from       = 32'd0;
    endtask

    function automatic void expect_byte(logic [7:0] value, logic last, status_t status);
        patched_byte_t r;
        r.value  = value;
        r.last   = last;
        r.status = status;
        expected_bytes.push_back(r);
    endfunction

    // Works out the results of one accepted byte and updates the parser copy.
    task automatic predict_byte(input logic [7:0] b, input logic last);
        logic [31:0] pos;
        logic [31:0] tag;
        logic [63:0] p;
        logic [63:0] size;
        logic [63:0] res;
        logic [63:0] sum;
        status_t     st;
        int          width;
        int          k;
        pos      = next_pos;
        next_pos = pos + 32'd1;
        if (table_phase == PH_ERROR) begin
            if (last) clear_scan_state();
            return;
        end
        byte_window = {byte_window[55:0], b};
        tag         = byte_window[31:0];
        st          = ST_OK;
        width       = table_wide ? 8 : 4;
        if (pos == CMOV_END_POS && table_phase != PH_ENTRIES && tag == TAG_CMOV) begin
            st = ST_CMOV;
        end else if (table_phase == PH_SCAN) begin
            if (pos >= 32'd7 && (tag == TAG_STCO || tag == TAG_CO64)) begin
                p = {32'd0, pos} - 64'd3;
                if (p + 64'd4 < {32'd0, moov_len_model} && p >= {32'd0, rescan_from}) begin
                    size = {32'd0, byte_window[63:32]};
                    if (size < {32'd0, MIN_ATOM_SIZE} ||
                        p + size - 64'd4 > {32'd0, moov_len_model}) begin
                        st = ST_BAD_SIZE;
                    end else begin
                        res               = p + size - 64'd3;
                        table_wide        = (tag == TAG_CO64);
                        rescan_from       = (res > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : res[31:0];
                        entries_remaining = 32'd0;
                        entry_fill        = 0;
                        table_phase       = PH_HEADER;
                    end
                end
            end
        end else if (table_phase == PH_HEADER) begin
            // Version and flags pass through untouched.
            entry_fill++;
            if (entry_fill >= 4) begin
                entry_fill  = 0;
                table_phase = PH_COUNT;
            end
        end else if (table_phase == PH_COUNT) begin
            entries_remaining = {entries_remaining[23:0], b};
            entry_fill++;
            if (entry_fill >= 4) begin
                entry_fill  = 0;
                entry_bytes = 64'd0;
                if ({32'd0, pos} + 64'd1 + {32'd0, entries_remaining} * 64'(width) >
                    {32'd0, moov_len_model})
                    st = ST_BAD_COUNT;
                else
                    table_phase = (entries_remaining == 32'd0) ? PH_SCAN : PH_ENTRIES;
            end
        end else begin
            // Entry bytes are held until the offset is complete.
            entry_bytes = {entry_bytes[55:0], b};
            entry_fill++;
            if (entry_fill >= width) begin
                sum = entry_bytes + {32'd0, moov_len_model};
                if (table_wide) begin
                    byte_window = sum;
                end else begin
                    sum               = {32'd0, sum[31:0]};
                    byte_window[31:0] = sum[31:0];
                end
                for (k = width - 1; k >= 0; k--)
                    expect_byte(sum[8*k +: 8], (k == 0) ? last : 1'b0, ST_OK);
                entry_fill        = 0;
                entry_bytes       = 64'd0;
                entries_remaining = entries_remaining - 32'd1;
                if (entries_remaining == 32'd0) table_phase = PH_SCAN;
            end else if (last) begin
                // A final byte inside an entry flushes the held bytes unpatched.
                for (k = entry_fill - 1; k >= 0; k--)
                    expect_byte(entry_bytes[8*k +: 8], (k == 0), ST_OK);
            end
            if (last) clear_scan_state();
            return;
        end
        if (st != ST_OK) begin
            expect_byte(8'h00, 1'b1, st);
            table_phase = PH_ERROR;
        end else begin
            expect_byte(b, last, ST_OK);
        end
        if (last) clear_scan_state();
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR: result %0d: %s", results_seen, what);
        mismatch_count++;
    endtask

    // Monitor: samples both channels at the rising edge.
    always @(posedge aclk) begin
        in_taken = aresetn && s_tvalid && s_tready;
        if (in_taken) predict_byte(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction, byte %02h", m_tdata));
            end else begin
                oldest = expected_bytes.pop_front();
                if (m_tdata !== oldest.value)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              m_tdata, oldest.value));
                if (m_tlast !== oldest.last)
                    report_mismatch($sformatf("out_last %b, expected %b",
                                              m_tlast, oldest.last));
                if (m_tuser !== oldest.status)
                    report_mismatch($sformatf("status %0d, expected %s",
                                              m_tuser, oldest.status.name()));
            end
            results_seen++;
        end
    end

    // Driver: offers queued bytes in bursts separated by random gaps.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (in_taken || !s_tvalid) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                next_item = pending_bytes.pop_front();
                s_tdata  <= next_item.value;
                s_tlast  <= next_item.last;
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: a random stall mask, sometimes fully ready, plus one long hold-off.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            if (stall_slot == 0) begin
                stall_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
                stall_slot = 16;
            end
            stall_slot--;
            m_tready <= stall_mask[stall_slot];
        end
    end

    // Cycle limit.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ERROR: no progress after %0d cycles", CYCLE_LIMIT);
            $display("chunk_offset_table_patcher verification failed");
            $finish;
        end
    end

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_moov_length(input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MOOV_LENGTH_ADDR;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        moov_len_model = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic void queue_byte(logic [7:0] value, logic last);
        stream_byte_t item;
        item.value = value;
        item.last  = last;
        pending_bytes.push_back(item);
    endfunction

    function automatic void put_word(logic [31:0] w);
        int i;
        for (i = 3; i >= 0; i--) image_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic void put_noise(int n);
        int i;
        for (i = 0; i < n; i++) image_bytes.push_back(8'($urandom));
    endfunction

    // Appends one chunk offset table atom with random offsets.
    task automatic add_table(input bit wide, input int count,
                             input logic [31:0] size_field, input logic [31:0] count_field);
        logic [63:0] value;
        int          i;
        int          j;
        put_word(size_field);
        put_word(wide ? TAG_CO64 : TAG_STCO);
        put_word($urandom);
        put_word(count_field);
        entries_at = image_bytes.size();
        for (i = 0; i < count; i++) begin
            case ($urandom_range(0, 7))
                0: value = '1;
                1: value = 64'd0;
                // Offsets that spell a type tag must not start a new table.
                2: value = wide ? {TAG_STCO, 32'($urandom)} : {32'd0, TAG_CO64};
                default: value = {32'($urandom), 32'($urandom)};
            endcase
            for (j = (wide ? 8 : 4) - 1; j >= 0; j--) image_bytes.push_back(value[8*j +: 8]);
        end
    endtask

    // Builds one moov atom, where it is cut off, and the length to program.
    task automatic build_atom(input atom_shape_e shape, input bit huge_len, input int entries);
        int          count;
        int          width;
        int          total;
        int          filler;
        bit          wide;
        logic [31:0] size_field;
        logic [31:0] count_field;
        image_bytes.delete();
        put_word(32'd0);
        put_word(MOOV_TAG);
        count = 0;
        width = 4;
        case (shape)
            SH_CMOV: begin
                put_word($urandom_range(8, 64));
                put_word(TAG_CMOV);
                put_noise($urandom_range(0, 8));
            end
            SH_NOISE: begin
                put_noise($urandom_range(0, 12));
                if ($urandom_range(0, 1)) put_word($urandom_range(0, 1) ? TAG_STCO : TAG_CO64);
                put_noise($urandom_range(0, 12));
            end
            default: begin
                if ($urandom_range(0, 1)) begin
                    filler = $urandom_range(0, 5);
                    put_word(32'd8 + filler);
                    put_word(FREE_TAG);
                    put_noise(filler);
                end
                wide  = (shape == SH_CO64) ? 1'b1 :
                        (shape == SH_STCO) ? 1'b0 : 1'($urandom_range(0, 1));
                count = (shape == SH_CUT && entries == 0) ? 1 : entries;
                width = wide ? 8 : 4;
                size_field  = MIN_ATOM_SIZE + count * width;
                count_field = count;
                if (shape == SH_BAD_SIZE)
                    size_field = $urandom_range(0, 1) ? $urandom_range(0, 15)
                                                      : size_field + $urandom_range(4, 300);
                if (shape == SH_BAD_COUNT)
                    count_field = $urandom_range(0, 1) ? 32'hFFFF_FFFF
                                                       : count + $urandom_range(1, 40);
                add_table(wide, count, size_field, count_field);
                if ((shape == SH_STCO || shape == SH_CO64) && $urandom_range(0, 2) == 0) begin
                    filler = $urandom_range(0, 2);
                    wide   = 1'($urandom_range(0, 1));
                    add_table(wide, filler, MIN_ATOM_SIZE + filler * (wide ? 8 : 4), filler);
                end
                if (shape != SH_CUT) put_noise($urandom_range(0, 3));
            end
        endcase
        total          = image_bytes.size();
        image_bytes[0] = total[31:24];
        image_bytes[1] = total[23:16];
        image_bytes[2] = total[15:8];
        image_bytes[3] = total[7:0];
        atom_cut       = total;
        if (shape == SH_CUT) atom_cut = entries_at + $urandom_range(1, count * width - 1);
        if (huge_len)
            atom_moov_len = 32'hFFFF_FFFF;
        else if (shape == SH_NOISE)
            atom_moov_len = $urandom_range(0, 1) ? MOOV_LENGTH_RESET
                                                 : $urandom_range(16, total + 8);
        else if ((shape == SH_STCO || shape == SH_CO64) && $urandom_range(0, 3) == 0)
            atom_moov_len = $urandom_range(16, total);
        else
            atom_moov_len = total;
    endtask

    // Waits until every byte is accepted and every result has arrived.
    task automatic wait_until_drained();
        do @(posedge aclk);
        while (pending_bytes.size() != 0 || s_tvalid || expected_bytes.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // One atom under its own moov length setting.
    task automatic run_atom(input atom_shape_e shape, input bit huge_len, input int entries,
                            input bit long_hold);
        int i;
        build_atom(shape, huge_len, entries);
        write_moov_length(atom_moov_len);
        if (long_hold) hold_req = 1'b1;
        for (i = 0; i < atom_cut; i++) queue_byte(image_bytes[i], i == atom_cut - 1);
        random_items += atom_cut;
        wait_until_drained();
    endtask

    // Test sequence.
    initial begin
        atom_shape_e shape;
        int          pick;
        moov_len_model = MOOV_LENGTH_RESET;
        clear_scan_state();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: compressed moov at the smallest length, bytes after the
        // fault, then single-byte atoms at both byte extremes.
        write_moov_length(MOOV_LENGTH_RESET);
        image_bytes.delete();
        put_word(32'd32);
        put_word(MOOV_TAG);
        put_word(32'd8);
        put_word(TAG_CMOV);
        foreach (image_bytes[i]) queue_byte(image_bytes[i], 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b1);
        wait_until_drained();

        // Both table kinds, two faults, a cut atom; the first with a long hold-off.
        run_atom(SH_STCO, 1'b0, 4, 1'b1);
        run_atom(SH_CO64, 1'b1, 2, 1'b0);
        run_atom(SH_BAD_SIZE, 1'b0, 1, 1'b0);
        run_atom(SH_BAD_COUNT, 1'b0, 1, 1'b0);
        run_atom(SH_CUT, 1'b0, 2, 1'b0);

        // Random atoms, half of them well-formed tables.
        while (random_items < RANDOM_ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3, 4: shape = pick[0] ? SH_CO64 : SH_STCO;
                5:             shape = SH_BAD_SIZE;
                6:             shape = SH_BAD_COUNT;
                7:             shape = SH_CUT;
                8:             shape = SH_CMOV;
                default:       shape = SH_NOISE;
            endcase
            run_atom(shape, (pick < 5) && ($urandom_range(0, 4) == 0),
                     $urandom_range(0, 3), 1'b0);
        end

        if (mismatch_count == 0) begin
            $display("chunk_offset_table_patcher verification clean");
        end else begin
            $display("chunk_offset_table_patcher verification failed");
        end
        $finish;
    end

endmodule
